// ===== src/wpe_pkg.sv =====
// Shared types, register codes and reset timings of the LED serial encoder.
// No dependencies; every other file refers to it by scoped names.
package wpe_pkg;

  // Widths of the timing registers and of the config index
  localparam int unsigned CycW     = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned DefPixelBits = 24;

  // Depth of the pixel queue between front and back
  localparam int unsigned PixQDepth = 2;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegOneHigh  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegOneLow   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegZeroHigh = 3'd2;
  localparam logic [CfgIdxW-1:0] RegZeroLow  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegLatch    = 3'd4;

  // Reset timings in clock cycles
  localparam logic [CycW-1:0] RstOneHigh  = 16'd140;
  localparam logic [CycW-1:0] RstOneLow   = 16'd160;
  localparam logic [CycW-1:0] RstZeroHigh = 16'd70;
  localparam logic [CycW-1:0] RstZeroLow  = 16'd120;
  localparam logic [CycW-1:0] RstLatch    = 16'd12000;

  // Segment durations as seen by the serializer, zero already raised to one
  typedef struct packed {
    logic [CycW-1:0] one_high;
    logic [CycW-1:0] one_low;
    logic [CycW-1:0] zero_high;
    logic [CycW-1:0] zero_low;
    logic [CycW-1:0] latch;
  } timing_t;

  // A segment duration of zero is raised to one
  function automatic logic [CycW-1:0] at_least_one(input logic [CycW-1:0] v);
    at_least_one = (v == '0) ? {{(CycW-1){1'b0}}, 1'b1} : v;
  endfunction

endpackage

// ===== src/wpe_cfg_regs.sv =====
// Timing register file of the LED serial encoder: decodes writes, clamps values.
// Depends on wpe_pkg.
module wpe_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [wpe_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [wpe_pkg::CycW-1:0]     cfg_wdata_i,
  output wpe_pkg::timing_t             timing_o
);

  logic [wpe_pkg::CycW-1:0] one_high_q, one_low_q, zero_high_q, zero_low_q, latch_q;

  // Update the addressed register, drop writes to unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      one_high_q  <= wpe_pkg::RstOneHigh;
      one_low_q   <= wpe_pkg::RstOneLow;
      zero_high_q <= wpe_pkg::RstZeroHigh;
      zero_low_q  <= wpe_pkg::RstZeroLow;
      latch_q     <= wpe_pkg::RstLatch;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wpe_pkg::RegOneHigh:  one_high_q  <= cfg_wdata_i;
        wpe_pkg::RegOneLow:   one_low_q   <= cfg_wdata_i;
        wpe_pkg::RegZeroHigh: zero_high_q <= cfg_wdata_i;
        wpe_pkg::RegZeroLow:  zero_low_q  <= cfg_wdata_i;
        wpe_pkg::RegLatch:    latch_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Raise zero durations to one
  assign timing_o.one_high  = wpe_pkg::at_least_one(one_high_q);
  assign timing_o.one_low   = wpe_pkg::at_least_one(one_low_q);
  assign timing_o.zero_high = wpe_pkg::at_least_one(zero_high_q);
  assign timing_o.zero_low  = wpe_pkg::at_least_one(zero_low_q);
  assign timing_o.latch     = wpe_pkg::at_least_one(latch_q);

endmodule

// ===== src/wpe_front.sv =====
// Front end of the LED serial encoder: accepts pixel requests into a short queue.
// Depends on wpe_pkg.
module wpe_front #(
  parameter int unsigned PIXEL_BITS = wpe_pkg::DefPixelBits
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic [PIXEL_BITS-1:0] pixel_color_i,
  input  logic                  last_pixel_i,
  output logic                  pix_valid_o,
  input  logic                  pix_take_i,
  output logic [PIXEL_BITS-1:0] pix_color_o,
  output logic                  pix_last_o
);

  localparam int unsigned Depth = wpe_pkg::PixQDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [PIXEL_BITS-1:0] color_q [Depth];
  logic                  last_q  [Depth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign full        = (cnt_q == CntW'(Depth));
  assign pix_valid_o = (cnt_q != '0);
  assign do_push     = push && !full;
  assign do_pop      = pix_take_i && pix_valid_o;

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the pixel request
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      color_q[wr_ptr_q] <= pixel_color_i;
      last_q[wr_ptr_q]  <= last_pixel_i;
    end
  end

  assign pix_color_o = color_q[rd_ptr_q];
  assign pix_last_o  = last_q[rd_ptr_q];

endmodule

// ===== src/wpe_back.sv =====
// Back end of the LED serial encoder: serializes pixels into timed segments
// and holds each segment in an output register. Depends on wpe_pkg.
module wpe_back #(
  parameter int unsigned PIXEL_BITS = wpe_pkg::DefPixelBits
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  wpe_pkg::timing_t          timing_i,
  input  logic                      pix_valid_i,
  output logic                      pix_take_o,
  input  logic [PIXEL_BITS-1:0]     pix_color_i,
  input  logic                      pix_last_i,
  output logic                      empty,
  input  logic                      pop,
  output logic                      line_level_o,
  output logic [wpe_pkg::CycW-1:0]  segment_cycles_o,
  output logic                      last_segment_o
);

  localparam int unsigned BitCntW = $clog2(PIXEL_BITS);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StHigh  = 2'd1;
  localparam logic [1:0] StLow   = 2'd2;
  localparam logic [1:0] StLatch = 2'd3;

  logic [1:0]               state_q, state_d;
  logic [PIXEL_BITS-1:0]    shreg_q, shreg_d;
  logic [BitCntW-1:0]       bit_cnt_q, bit_cnt_d;
  logic                     latch_q, latch_d;
  logic                     out_valid_q, out_valid_d;
  logic                     out_ready, emit, finish, cur_bit;
  logic                     seg_level, seg_last;
  logic [wpe_pkg::CycW-1:0] seg_cycles;

  assign out_ready = !out_valid_q || pop;
  assign emit      = (state_q != StIdle) && out_ready;
  assign cur_bit   = shreg_q[PIXEL_BITS-1];

  // Form the segment of the current phase
  always_comb begin
    seg_level  = 1'b0;
    seg_last   = 1'b0;
    seg_cycles = timing_i.latch;
    unique case (state_q)
      StHigh: begin
        seg_level  = 1'b1;
        seg_cycles = cur_bit ? timing_i.one_high : timing_i.zero_high;
      end
      StLow: begin
        seg_cycles = cur_bit ? timing_i.one_low : timing_i.zero_low;
        seg_last   = (bit_cnt_q == '0) && !latch_q;
      end
      StLatch: begin
        seg_last   = 1'b1;
      end
      default: ;
    endcase
  end

  // Step through high, low and latch phases; load the next pixel on finish
  always_comb begin
    state_d    = state_q;
    shreg_d    = shreg_q;
    bit_cnt_d  = bit_cnt_q;
    latch_d    = latch_q;
    finish     = 1'b0;
    pix_take_o = 1'b0;
    unique case (state_q)
      StIdle: finish = 1'b1;
      StHigh: begin
        if (emit) begin
          state_d = StLow;
        end
      end
      StLow: begin
        if (emit) begin
          if (bit_cnt_q != '0) begin
            shreg_d   = {shreg_q[PIXEL_BITS-2:0], 1'b0};
            bit_cnt_d = bit_cnt_q - 1'b1;
            state_d   = StHigh;
          end else if (latch_q) begin
            state_d = StLatch;
          end else begin
            finish = 1'b1;
          end
        end
      end
      StLatch: begin
        if (emit) begin
          finish = 1'b1;
        end
      end
      default: ;
    endcase
    if (finish) begin
      if (pix_valid_i) begin
        pix_take_o = 1'b1;
        shreg_d    = pix_color_i;
        bit_cnt_d  = BitCntW'(PIXEL_BITS - 1);
        latch_d    = pix_last_i;
        state_d    = StHigh;
      end else begin
        state_d = StIdle;
      end
    end
  end

  // Hold the segment until it is popped
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shreg_q   <= shreg_d;
    bit_cnt_q <= bit_cnt_d;
    latch_q   <= latch_d;
    if (emit) begin
      line_level_o     <= seg_level;
      segment_cycles_o <= seg_cycles;
      last_segment_o   <= seg_last;
    end
  end

  assign empty = !out_valid_q;

endmodule

// ===== src/ws2812_pulse_encoder.sv =====
// Serial encoder for WS2812-style LED data: each pushed pixel becomes
// 2*PIXEL_BITS timed line segments (high then low per bit, MSB first), plus
// one low latch segment when last_pixel_i is set. Segments leave at one per
// cycle when popped, from the single serializer stepping one segment at a
// time; a two-entry pixel queue lets new pixels be pushed while the current
// one is still being serialized. Timing registers 0..4 (one high, one low,
// zero high, zero low, latch) are written through cfg_we_i; a value of zero
// acts as one. Depends on wpe_pkg, wpe_cfg_regs, wpe_front and wpe_back.
module ws2812_pulse_encoder #(
  parameter int unsigned PIXEL_BITS = wpe_pkg::DefPixelBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [wpe_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [wpe_pkg::CycW-1:0]     cfg_wdata_i,
  input  logic                         push,
  output logic                         full,
  input  logic [PIXEL_BITS-1:0]        pixel_color_i,
  input  logic                         last_pixel_i,
  output logic                         empty,
  input  logic                         pop,
  output logic                         line_level_o,
  output logic [wpe_pkg::CycW-1:0]     segment_cycles_o,
  output logic                         last_segment_o
);

  wpe_pkg::timing_t      timing;
  logic                  pix_valid, pix_take, pix_last;
  logic [PIXEL_BITS-1:0] pix_color;

  // Timing registers
  wpe_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .timing_o    (timing)
  );

  // Pixel queue
  wpe_front #(.PIXEL_BITS(PIXEL_BITS)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .pixel_color_i (pixel_color_i),
    .last_pixel_i  (last_pixel_i),
    .pix_valid_o   (pix_valid),
    .pix_take_i    (pix_take),
    .pix_color_o   (pix_color),
    .pix_last_o    (pix_last)
  );

  // Segment serializer and output register
  wpe_back #(.PIXEL_BITS(PIXEL_BITS)) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .timing_i         (timing),
    .pix_valid_i      (pix_valid),
    .pix_take_o       (pix_take),
    .pix_color_i      (pix_color),
    .pix_last_i       (pix_last),
    .empty            (empty),
    .pop              (pop),
    .line_level_o     (line_level_o),
    .segment_cycles_o (segment_cycles_o),
    .last_segment_o   (last_segment_o)
  );

endmodule
